// ----- hw/rtl/hrm_pkg.sv -----
// Shared types and constants for the running-mode histogram block.
package hrm_pkg;

   // Request kind codes
   localparam logic KIND_CLEAR = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Width of the generation tag kept with every histogram entry
   localparam int unsigned EPOCH_BITS = 8;

   // Request payload
   typedef struct packed {
      logic        kind;
      logic [15:0] event_id;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [15:0] leader_id;
      logic [15:0] leader_count;
   } rsp_type;

endpackage

// ----- hw/rtl/histogram_running_mode.sv -----
// Running-mode histogram: per-identifier counts in one memory, leader tracking.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req_    | in        | req_valid, req_stall | hrm_pkg::req_type (kind, event_id)
//  rsp_    | out       | rsp_valid, rsp_stall | hrm_pkg::rsp_type (leader_id, count)
//
// One request per cycle unless stalled; it passes the stage, then the response register;
// counts come from one read-modify-write loop on the count memory, last write forwarded.
// Clears bump a generation tag; after reset and after every 2^EPOCH_BITS-th clear a sweep
// zeroes all 2^ID_BITS entries, one per cycle, and requests stall for those cycles
// (and at a wrap also while the clear leaves the stage). Reset is synchronous,
// active high. A stalled response holds the stage and stalls requests once it fills.
module histogram_running_mode #(
   parameter int unsigned ID_BITS    = 16,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hrm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrm_pkg::rsp_type rsp_data
);

   localparam int unsigned MEM_W     = COUNT_BITS + hrm_pkg::EPOCH_BITS;
   localparam int unsigned MEM_DEPTH = 2 ** ID_BITS;

   // Sequencer codes
   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   // Count memory: {generation tag, count}
   logic [MEM_W-1:0] mem [MEM_DEPTH];

   logic                          state_ff, state_in;
   logic [ID_BITS-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [hrm_pkg::EPOCH_BITS-1:0] epoch_ff, epoch_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_kind_ff;
   logic [ID_BITS-1:0]   s1_id_ff;
   logic [MEM_W-1:0]     rd_ff;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ID_BITS-1:0]    fwd_id_ff;
   logic [COUNT_BITS-1:0] fwd_count_ff;

   logic [ID_BITS-1:0]    best_id_ff, best_id_in;
   logic [COUNT_BITS-1:0] best_count_ff, best_count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   hrm_pkg::rsp_type rsp_data_ff;

   logic                           req_acc;
   logic [ID_BITS-1:0]             req_id;
   logic                           s1_adv;
   logic                           s1_clear;
   logic                           wrap_hold;
   logic [hrm_pkg::EPOCH_BITS-1:0] rd_tag;
   logic [COUNT_BITS-1:0]          rd_cnt;
   logic [COUNT_BITS-1:0]          cur_cnt;
   logic [COUNT_BITS-1:0]          new_cnt;
   logic                           not_sat;
   logic                           cnt_wr;
   logic                           wr_en;
   logic [ID_BITS-1:0]             wr_addr;
   logic [MEM_W-1:0]               wr_data;

   // Handshake and stage control
   assign req_id    = ID_BITS'(req_data.event_id);
   assign s1_clear  = (s1_kind_ff == hrm_pkg::KIND_CLEAR);
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign wrap_hold = s1_valid_ff && s1_clear && (epoch_ff == '1);
   assign req_stall = (state_ff == ST_SWEEP) || wrap_hold || (s1_valid_ff && !s1_adv);
   assign req_acc   = req_valid && !req_stall;

   // Resolve the current count: forwarded write, tagged memory word, or zero
   assign rd_tag  = rd_ff[MEM_W-1 -: hrm_pkg::EPOCH_BITS];
   assign rd_cnt  = rd_ff[COUNT_BITS-1:0];
   always_comb begin
      if (fwd_valid_ff && (fwd_id_ff == s1_id_ff)) begin
         cur_cnt = fwd_count_ff;
      end else if (rd_tag == epoch_ff) begin
         cur_cnt = rd_cnt;
      end else begin
         cur_cnt = '0;
      end
   end
   assign not_sat = (cur_cnt != '1);
   assign new_cnt = cur_cnt + COUNT_BITS'(1);
   assign cnt_wr  = s1_adv && !s1_clear && not_sat;

   // Memory write port: sweep or count update
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cnt_wr;
         wr_addr = s1_id_ff;
         wr_data = {epoch_ff, new_cnt};
      end
   end

   // Leader update
   always_comb begin
      best_id_in    = best_id_ff;
      best_count_in = best_count_ff;
      if (s1_adv && s1_clear) begin
         best_id_in    = '0;
         best_count_in = '0;
      end else if (cnt_wr && (new_cnt > best_count_ff)) begin
         best_id_in    = s1_id_ff;
         best_count_in = new_cnt;
      end
   end

   // Generation, forwarding and sequencer next state
   always_comb begin
      epoch_in      = epoch_ff;
      fwd_valid_in  = fwd_valid_ff;
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      if (s1_adv && s1_clear) begin
         epoch_in     = epoch_ff + hrm_pkg::EPOCH_BITS'(1);
         fwd_valid_in = 1'b0;
      end else if (cnt_wr) begin
         fwd_valid_in = 1'b1;
      end
      case (state_ff)
         ST_RUN: begin
            if (wrap_hold && s1_adv) begin
               state_in      = ST_SWEEP;
               sweep_addr_in = '0;
            end
         end
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + ID_BITS'(1);
            if (sweep_addr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Stage and response valid
   always_comb begin
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Count memory: registered read on acceptance, one write per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_acc) begin
         rd_ff <= mem[req_id];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         epoch_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         best_id_ff    <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff      <= epoch_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         best_id_ff    <= best_id_in;
         best_count_ff <= best_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_kind_ff <= req_data.kind;
         s1_id_ff   <= req_id;
      end
      if (cnt_wr) begin
         fwd_id_ff    <= s1_id_ff;
         fwd_count_ff <= new_cnt;
      end
      if (s1_adv) begin
         rsp_data_ff.leader_id    <= 16'(best_id_in);
         rsp_data_ff.leader_count <= 16'(best_count_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // No request is taken while the sweep owns the memory
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_acc)
      else $error("request accepted during sweep");

   // Count updates never collide with the sweep
   a_no_update_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !cnt_wr)
      else $error("count update during sweep");

   // A clear always reports an empty leader
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_clear) |=>
         (rsp_valid_ff && rsp_data_ff.leader_id == 16'd0 && rsp_data_ff.leader_count == 16'd0))
      else $error("clear response not zero");

   // The leading count only grows between clears
   a_leader_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && s1_clear) |=> (best_count_ff >= $past(best_count_ff)))
      else $error("leader count decreased without clear");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the running-mode histogram block.
`timescale 1ns / 1ps

module tb_top;

   localparam int          CYCLE_LIMIT = 2_000_000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   hrm_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   hrm_pkg::rsp_type rsp_data;

   // Shadow histogram: only identifiers touched since the last clear are present
   logic [15:0]      shadow_count [logic [15:0]];
   logic [15:0]      shadow_leader_id;
   logic [15:0]      shadow_leader_count;
   hrm_pkg::rsp_type leader_expect_q [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int stall_hold_left;
   int mismatch_count;
   int request_total;
   int clear_total;
   int cycle_count;
   int peak_leader_count;

   histogram_running_mode u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Update the shadow histogram and return the leader after this request
   function automatic hrm_pkg::rsp_type predict_leader(input hrm_pkg::req_type r);
      logic [15:0]      cnt;
      hrm_pkg::rsp_type res;
      if (r.kind == hrm_pkg::KIND_CLEAR) begin
         shadow_count.delete();
         shadow_leader_id    = '0;
         shadow_leader_count = '0;
      end else begin
         cnt = shadow_count.exists(r.event_id) ? shadow_count[r.event_id] : 16'h0000;
         // Saturated counts stay put and never move the leader
         if (cnt != COUNT_MAX) begin
            cnt = cnt + 16'd1;
            shadow_count[r.event_id] = cnt;
            if (cnt > shadow_leader_count) begin
               shadow_leader_id    = r.event_id;
               shadow_leader_count = cnt;
            end
         end
      end
      if (int'(shadow_leader_count) > peak_leader_count) begin
         peak_leader_count = int'(shadow_leader_count);
      end
      res.leader_id    = shadow_leader_id;
      res.leader_count = shadow_leader_count;
      return res;
   endfunction

   function automatic hrm_pkg::req_type make_req(input logic kind, input logic [15:0] id);
      hrm_pkg::req_type r;
      r.kind     = kind;
      r.event_id = id;
      return r;
   endfunction

   // Offer one request; returns right after the edge that takes it, valid still high
   task automatic send_request(input hrm_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      leader_expect_q.push_back(predict_leader(r));
      request_total++;
      if (r.kind == hrm_pkg::KIND_CLEAR) clear_total++;
   endtask

   // Drop valid and hold until every outstanding response has been checked
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (leader_expect_q.size() != 0) @(posedge clock);
   endtask

   // Ties, leader changes, extreme identifiers and back-to-back clears
   task automatic test_directed_cases();
      send_request(make_req(hrm_pkg::KIND_CLEAR, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h0000));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h0000));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h0000));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h8000));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h7FFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h5555));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hAAAA));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h5555));
      send_request(make_req(hrm_pkg::KIND_CLEAR, 16'h0000));
      send_request(make_req(hrm_pkg::KIND_CLEAR, 16'hAAAA));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h0001));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h0001));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'hFFFF));
      send_request(make_req(hrm_pkg::KIND_CLEAR, 16'h5555));
      send_request(make_req(hrm_pkg::KIND_EVENT, 16'h1234));
      drain_responses();
   endtask

   // Probe identifiers exactly 256 clears after they were last counted,
   // so a stale generation tag would show up as a count above one
   task automatic test_clear_generations();
      logic [15:0] base;
      int          rnd;
      base = 16'($urandom);
      for (rnd = 0; rnd < 260; rnd++) begin
         send_request(make_req(hrm_pkg::KIND_EVENT, base + 16'(rnd)));
         if (rnd >= 256) begin
            send_request(make_req(hrm_pkg::KIND_EVENT, base + 16'(rnd - 256)));
         end
         send_request(make_req(hrm_pkg::KIND_CLEAR, 16'($urandom)));
      end
      drain_responses();
   endtask

   // Runs of one identifier, broken by another every fifth request, so most counts come from the last write
   task automatic test_same_id_runs();
      logic [15:0] run_id;
      logic [15:0] other_id;
      int          n;
      run_id   = 16'($urandom);
      other_id = ~run_id;
      send_request(make_req(hrm_pkg::KIND_CLEAR, 16'h0000));
      for (n = 0; n < 40; n++) begin
         if (n % 5 == 4) send_request(make_req(hrm_pkg::KIND_EVENT, other_id));
         else send_request(make_req(hrm_pkg::KIND_EVENT, run_id));
      end
      send_request(make_req(hrm_pkg::KIND_CLEAR, run_id));
      send_request(make_req(hrm_pkg::KIND_EVENT, run_id));
      drain_responses();
   endtask

   // Bursts over small identifier pools so counts climb and leaders trade places
   task automatic test_random_bursts(input int n_items);
      logic [15:0] pool [6];
      int          sent;
      int          pool_n;
      int          burst_len;
      int          k;
      sent = 0;
      while (sent < n_items) begin
         pool_n = $urandom_range(1, 6);
         for (k = 0; k < 6; k++) begin
            case ($urandom_range(0, 7))
               0:       pool[k] = 16'h0000;
               1:       pool[k] = 16'hFFFF;
               default: pool[k] = 16'($urandom);
            endcase
         end
         burst_len = $urandom_range(1, 40);
         for (k = 0; k < burst_len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_request(make_req(hrm_pkg::KIND_EVENT, 16'($urandom)));
            end else begin
               send_request(make_req(hrm_pkg::KIND_EVENT, pool[$urandom_range(0, pool_n - 1)]));
            end
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            send_request(make_req(hrm_pkg::KIND_CLEAR, 16'($urandom)));
            sent++;
         end
      end
      drain_responses();
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      logic [15:0] pool [3];
      int          k;
      for (k = 0; k < 3; k++) pool[k] = 16'($urandom);
      @(posedge clock);
      stall_hold_left = 300;
      for (k = 0; k < 80; k++) begin
         if (k == 40) send_request(make_req(hrm_pkg::KIND_CLEAR, 16'($urandom)));
         else send_request(make_req(hrm_pkg::KIND_EVENT, pool[$urandom_range(0, 2)]));
      end
      drain_responses();
   endtask

   // Response side: long hold first, otherwise random stalls
   always @(negedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall = 1'b1;
         stall_hold_left--;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Compare every accepted response with the oldest prediction
   always @(posedge clock) begin
      hrm_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (leader_expect_q.size() == 0) begin
            $error("unexpected response: leader_id %0d, leader_count %0d",
                   rsp_data.leader_id, rsp_data.leader_count);
            mismatch_count++;
         end else begin
            exp_rsp = leader_expect_q.pop_front();
            if (rsp_data.leader_id !== exp_rsp.leader_id) begin
               $error("leader_id mismatch: expected %0d, actual %0d",
                      exp_rsp.leader_id, rsp_data.leader_id);
               mismatch_count++;
            end
            if (rsp_data.leader_count !== exp_rsp.leader_count) begin
               $error("leader_count mismatch: expected %0d, actual %0d",
                      exp_rsp.leader_count, rsp_data.leader_count);
               mismatch_count++;
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, leader_expect_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_data            = '0;
      stall_hold_left     = 0;
      mismatch_count      = 0;
      request_total       = 0;
      clear_total         = 0;
      cycle_count         = 0;
      peak_leader_count   = 0;
      shadow_leader_id    = '0;
      shadow_leader_count = '0;

      // Sender mostly active, receiver stalls often
      sender_idle_pct    = 15;
      receiver_stall_pct = 50;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_clear_generations();

      // Sender often idle, receiver stalls rarely
      sender_idle_pct    = 50;
      receiver_stall_pct = 15;
      test_random_bursts(190);

      // Full rate on both sides
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_same_id_runs();
      test_random_bursts(190);
      test_backpressure();

      drain_responses();
      repeat (10) @(posedge clock);

      $display("Checked %0d requests including %0d clears in %0d cycles.",
               request_total, clear_total, cycle_count);
      $display("Peak leader count %0d; generation wrap, same-identifier runs and long stall covered.",
               peak_leader_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/hrm_pkg.sv
hw/rtl/histogram_running_mode.sv
dv/tb_top.sv
